FILE: hdl/bwf_pkg.sv
package bwf_pkg;

  // request kinds
  localparam logic REQ_LOAD  = 1'b0;
  localparam logic REQ_ALLOC = 1'b1;

  // fit policies
  localparam logic POL_BEST  = 1'b0;
  localparam logic POL_WORST = 1'b1;

  // result status codes
  localparam logic [1:0] ST_ALLOC  = 2'd0;
  localparam logic [1:0] ST_NOFIT  = 2'd1;
  localparam logic [1:0] ST_LOADED = 2'd2;

  // fixed field widths
  localparam int SIZE_W = 32;
  localparam int SLOT_W = 5;
  localparam int PORT_ADDR_W = 32;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;   // latch the accepted beat, clear the pick
    logic cnt_clr;   // restart the slot counter
    logic clr_wr;    // write an empty entry at the counter
    logic scan_rd;   // read the entry at the counter
    logic do_load;   // write the loaded slot and post its result
    logic do_alloc;  // write back the picked slot and post the result
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic cnt_last;  // counter sits on the last slot
    logic out_free;  // result register can take a new beat
  } sts_t;

endpackage

FILE: hdl/best_worst_fit_block_allocator.sv
// Free block allocator with best fit and worst fit policies.
// Input channel (in_*): one beat is a load (writes one table slot with a start
// and a size, size zero empties the slot) or an allocate (asks for in_req_size
// under in_fit_policy). Result channel (out_*): exactly one beat per input beat,
// in order, carrying a status, the granted start and the granted size.
// Both channels use valid/stall; a beat moves when valid is high and stall low.
// Sequence: a load writes its slot and posts its result from S_LOAD; an
// allocate reads every slot through the single table read port, one per
// cycle, passes S_DRAIN and posts its result from S_FINISH. Both wait while
// the result register is held. The next beat is taken only after the result
// is posted, so a new beat is never taken while the last is in progress.
// Reset: a clearing pass writes every slot empty, one slot per cycle, with
// in_stall high. After that the table holds no free blocks.
// Receiver stall: the result sits in an output register; a new beat is still
// accepted, but its result waits until the held one has been taken.
module best_worst_fit_block_allocator #(
  parameter int ENTRIES   = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_req_type,
  input  logic                            in_fit_policy,
  input  logic [bwf_pkg::SIZE_W-1:0]      in_req_size,
  input  logic [bwf_pkg::SLOT_W-1:0]      in_slot_index,
  input  logic [bwf_pkg::PORT_ADDR_W-1:0] in_block_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [bwf_pkg::PORT_ADDR_W-1:0] out_granted_start,
  output logic [bwf_pkg::SIZE_W-1:0]      out_granted_size
);
  import bwf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  bwf_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_req_type),
    .in_stall    (in_stall),
    .sts         (sts),
    .cmd         (cmd)
  );

  // table, scan compare and result register
  bwf_dpath #(
    .ENTRIES   (ENTRIES),
    .ADDR_BITS (ADDR_BITS)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_fit_policy     (in_fit_policy),
    .in_req_size       (in_req_size),
    .in_slot_index     (in_slot_index),
    .in_block_start    (in_block_start),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_granted_start (out_granted_start),
    .out_granted_size  (out_granted_size)
  );

  // one beat at a time in flight
  a_single_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // a result never overwrites one still held by the receiver
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.do_load || cmd.do_alloc) |-> (!out_valid || !out_stall))
    else $error("result posted over a stalled beat");

  // the table port serves one user per cycle
  a_port_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_wr, cmd.scan_rd, cmd.do_load, cmd.do_alloc}))
    else $error("table port conflict");

  // only a grant carries a start and a size
  a_zero_unless_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_ALLOC) |->
      (out_granted_start == '0 && out_granted_size == '0 &&
       (out_status == ST_NOFIT || out_status == ST_LOADED)))
    else $error("bad non-grant result");

endmodule

FILE: hdl/bwf_ctrl.sv
module bwf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_req_type,
  output logic          in_stall,
  input  bwf_pkg::sts_t sts,
  output bwf_pkg::cmd_t cmd
);
  import bwf_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR  = 6'b000001,
    S_IDLE   = 6'b000010,
    S_LOAD   = 6'b000100,
    S_SCAN   = 6'b001000,
    S_DRAIN  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          cmd.cnt_clr = 1'b1;
          state_nxt   = (in_req_type == REQ_ALLOC) ? S_SCAN : S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts.out_free) begin
          cmd.do_load = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) begin
          cmd.cnt_clr = 1'b1;
          state_nxt   = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.do_alloc = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/bwf_dpath.sv
module bwf_dpath #(
  parameter int ENTRIES   = 32,
  parameter int ADDR_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  bwf_pkg::cmd_t                   cmd,
  output bwf_pkg::sts_t                   sts,
  input  logic                            in_fit_policy,
  input  logic [bwf_pkg::SIZE_W-1:0]      in_req_size,
  input  logic [bwf_pkg::SLOT_W-1:0]      in_slot_index,
  input  logic [bwf_pkg::PORT_ADDR_W-1:0] in_block_start,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [1:0]                      out_status,
  output logic [bwf_pkg::PORT_ADDR_W-1:0] out_granted_start,
  output logic [bwf_pkg::SIZE_W-1:0]      out_granted_size
);
  import bwf_pkg::*;

  localparam int IDX_W = $clog2(ENTRIES);

  // free block table
  logic [ADDR_BITS-1:0] mem_start [ENTRIES];
  logic [SIZE_W-1:0]    mem_size  [ENTRIES];

  // captured beat
  logic                 policy_r;
  logic [SIZE_W-1:0]    size_r;
  logic [SLOT_W-1:0]    slot_r;
  logic [PORT_ADDR_W-1:0] bstart_r;

  // slot counter and registered read
  logic [IDX_W-1:0]     cnt_r;
  logic                 rd_vld_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [ADDR_BITS-1:0] rd_start_r;
  logic [SIZE_W-1:0]    rd_size_r;

  // running pick
  logic                 found_r;
  logic [IDX_W-1:0]     pick_idx_r;
  logic [ADDR_BITS-1:0] pick_start_r;
  logic [SIZE_W-1:0]    pick_size_r;

  // result register
  logic                   out_valid_r;
  logic [1:0]             out_status_r;
  logic [PORT_ADDR_W-1:0] out_gstart_r;
  logic [SIZE_W-1:0]      out_gsize_r;

  logic                 hit;
  logic                 exact;
  logic                 slot_ok;
  logic [31:0]          slot_ext;
  logic [63:0]          bstart_ext;
  logic [63:0]          size_ext;
  logic [63:0]          pstart_ext;
  logic                 we;
  logic [IDX_W-1:0]     waddr;
  logic [ADDR_BITS-1:0] wstart;
  logic [SIZE_W-1:0]    wsize;

  assign sts.cnt_last = (cnt_r == IDX_W'(ENTRIES - 1));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign slot_ext   = 32'(slot_r);
  assign slot_ok    = (slot_ext < 32'(ENTRIES));
  assign bstart_ext = 64'(bstart_r);
  assign size_ext   = 64'(size_r);
  assign pstart_ext = 64'(pick_start_r);
  assign exact      = (pick_size_r == size_r);

  // candidate test on the entry just read
  assign hit = rd_vld_r && (rd_size_r != '0) && (rd_size_r >= size_r) &&
               (!found_r ||
                (policy_r == POL_BEST  && rd_size_r < pick_size_r) ||
                (policy_r == POL_WORST && rd_size_r > pick_size_r));

  // single write port select
  always_comb begin
    we     = 1'b0;
    waddr  = cnt_r;
    wstart = '0;
    wsize  = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.do_load) begin
      we     = slot_ok;
      waddr  = slot_ext[IDX_W-1:0];
      wstart = bstart_ext[ADDR_BITS-1:0];
      wsize  = size_r;
    end else if (cmd.do_alloc) begin
      we    = found_r;
      waddr = pick_idx_r;
      if (exact) begin
        wstart = pick_start_r;
        wsize  = '0;
      end else begin
        wstart = pick_start_r + size_ext[ADDR_BITS-1:0];
        wsize  = pick_size_r - size_r;
      end
    end
  end

  // table write and scan read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_start[waddr] <= wstart;
      mem_size[waddr]  <= wsize;
    end
    if (cmd.scan_rd) begin
      rd_start_r <= mem_start[cnt_r];
      rd_size_r  <= mem_size[cnt_r];
    end
    rd_idx_r <= cnt_r;
  end

  // slot counter and read valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_rd;
      if (cmd.cnt_clr) begin
        cnt_r <= '0;
      end else if (cmd.clr_wr || cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // beat capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      policy_r <= in_fit_policy;
      size_r   <= in_req_size;
      slot_r   <= in_slot_index;
      bstart_r <= in_block_start;
    end
  end

  // pick tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (cmd.capture) begin
      found_r <= 1'b0;
    end else if (hit) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (hit) begin
      pick_idx_r   <= rd_idx_r;
      pick_start_r <= rd_start_r;
      pick_size_r  <= rd_size_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_load || cmd.do_alloc) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_load) begin
      out_status_r <= ST_LOADED;
      out_gstart_r <= '0;
      out_gsize_r  <= '0;
    end else if (cmd.do_alloc) begin
      if (found_r) begin
        out_status_r <= ST_ALLOC;
        out_gstart_r <= pstart_ext[PORT_ADDR_W-1:0];
        out_gsize_r  <= size_r;
      end else begin
        out_status_r <= ST_NOFIT;
        out_gstart_r <= '0;
        out_gsize_r  <= '0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_granted_start = out_gstart_r;
  assign out_granted_size  = out_gsize_r;

endmodule

FILE: tb/alloc_result_checker.sv
module alloc_result_checker #(
  parameter int ENTRIES = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_req_type,
  input  logic                            in_fit_policy,
  input  logic [bwf_pkg::SIZE_W-1:0]      in_req_size,
  input  logic [bwf_pkg::SLOT_W-1:0]      in_slot_index,
  input  logic [bwf_pkg::PORT_ADDR_W-1:0] in_block_start,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      out_status,
  input  logic [bwf_pkg::PORT_ADDR_W-1:0] out_granted_start,
  input  logic [bwf_pkg::SIZE_W-1:0]      out_granted_size,
  output int                              fail_count,
  output int                              pending,
  output int                              granted_count,
  output int                              exact_count,
  output int                              nofit_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import bwf_pkg::*;

  typedef struct packed {
    logic [1:0]             status;
    logic [PORT_ADDR_W-1:0] start;
    logic [SIZE_W-1:0]      size;
  } grant_t;

  // mirror of the free block table
  logic [PORT_ADDR_W-1:0] mirror_start [ENTRIES];
  logic [SIZE_W-1:0]      mirror_size  [ENTRIES];

  grant_t expected_grants [$];
  int mismatches = 0;
  int grants     = 0;
  int exact_fits = 0;
  int misses     = 0;

  // apply one input beat to the mirror and return the result it causes
  function automatic grant_t predict_grant(input logic rtype, input logic pol,
                                           input logic [SIZE_W-1:0] size,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [PORT_ADDR_W-1:0] start);
    grant_t g;
    int pick;
    bit found;
    g = '0;
    pick = 0;
    found = 1'b0;
    if (rtype == REQ_LOAD) begin
      if (int'(slot) < ENTRIES) begin
        mirror_start[slot] = start;
        mirror_size[slot]  = size;
      end
      g.status = ST_LOADED;
      return g;
    end
    // scan in slot order, first found wins a tie
    for (int i = 0; i < ENTRIES; i++) begin
      if (mirror_size[i] == '0 || mirror_size[i] < size) continue;
      if (!found ||
          (pol == POL_BEST && mirror_size[i] < mirror_size[pick]) ||
          (pol == POL_WORST && mirror_size[i] > mirror_size[pick])) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (!found) begin
      misses++;
      g.status = ST_NOFIT;
      return g;
    end
    grants++;
    g.status = ST_ALLOC;
    g.start  = mirror_start[pick];
    g.size   = size;
    // exact fit empties the slot, otherwise keep the remainder
    if (mirror_size[pick] == size) begin
      exact_fits++;
      mirror_size[pick] = '0;
    end else begin
      mirror_start[pick] = mirror_start[pick] + size;
      mirror_size[pick]  = mirror_size[pick] - size;
    end
    return g;
  endfunction

  // predict on accepted input beats, compare accepted result beats
  always @(posedge clk) begin : watch
    grant_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        mirror_start[i] = '0;
        mirror_size[i]  = '0;
      end
      expected_grants.delete();
    end else begin
      if (in_valid && !in_stall) begin
        expected_grants.push_back(predict_grant(in_req_type, in_fit_policy, in_req_size,
                                                in_slot_index, in_block_start));
      end
      if (out_valid && !out_stall) begin
        if (expected_grants.size() == 0) begin
          mismatches++;
          $error("result beat with nothing expected: status %0d start %h size %h",
                 out_status, out_granted_start, out_granted_size);
        end else begin
          want = expected_grants.pop_front();
          if (out_status !== want.status) begin
            mismatches++;
            $error("status: expected %0d, got %0d", want.status, out_status);
          end
          if (out_granted_start !== want.start) begin
            mismatches++;
            $error("granted_start: expected %h, got %h", want.start, out_granted_start);
          end
          if (out_granted_size !== want.size) begin
            mismatches++;
            $error("granted_size: expected %h, got %h", want.size, out_granted_size);
          end
        end
      end
    end
    fail_count    <= mismatches;
    pending       <= expected_grants.size();
    granted_count <= grants;
    exact_count   <= exact_fits;
    nofit_count   <= misses;
  end

endmodule

FILE: tb/tb_best_worst_fit_block_allocator.sv
module tb_best_worst_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;
  import bwf_pkg::*;

  localparam int ENTRIES      = 32;
  localparam int RANDOM_ITEMS = 1850;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int SETTLE       = ENTRIES + 16;
  localparam int HOLD_FROM    = 2000;
  localparam int HOLD_CYCLES  = 400;

  logic                   clk;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_req_type;
  logic                   in_fit_policy;
  logic [SIZE_W-1:0]      in_req_size;
  logic [SLOT_W-1:0]      in_slot_index;
  logic [PORT_ADDR_W-1:0] in_block_start;
  logic                   out_valid;
  logic                   out_stall;
  logic [1:0]             out_status;
  logic [PORT_ADDR_W-1:0] out_granted_start;
  logic [SIZE_W-1:0]      out_granted_size;

  int fail_count;
  int pending;
  int granted_count;
  int exact_count;
  int nofit_count;
  int loads_sent  = 0;
  int allocs_sent = 0;
  int worst_sent  = 0;

  best_worst_fit_block_allocator u_top (.*);

  alloc_result_checker #(.ENTRIES(ENTRIES)) u_check (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin : watchdog
    int cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("run limit of %0d cycles reached", CYCLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // receiver: stall modes that change every stretch, one long hold
  initial begin : receiver
    int cyc;
    int run;
    int mode;
    cyc = 0;
    out_stall <= 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      run  = $urandom_range(10, 80);
      repeat (run) begin
        @(posedge clk);
        cyc++;
        if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_CYCLES) begin
          out_stall <= 1'b1;
        end else begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
          endcase
        end
      end
    end
  end

  // offer one beat and hold it until taken
  task automatic put_beat(input logic rtype, input logic pol,
                          input logic [SIZE_W-1:0] size,
                          input logic [SLOT_W-1:0] slot,
                          input logic [PORT_ADDR_W-1:0] start);
    in_valid       <= 1'b1;
    in_req_type    <= rtype;
    in_fit_policy  <= pol;
    in_req_size    <= size;
    in_slot_index  <= slot;
    in_block_start <= start;
    do @(posedge clk); while (in_stall);
    if (rtype == REQ_LOAD) begin
      loads_sent++;
    end else begin
      allocs_sent++;
      if (pol == POL_WORST) worst_sent++;
    end
  endtask

  task automatic pause_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // hold off until every expected result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // random beat, mostly small blocks so allocates keep finding fits
  task automatic send_random();
    logic [SIZE_W-1:0] size;
    logic [PORT_ADDR_W-1:0] start;
    if ($urandom_range(0, 99) < 35) begin
      case ($urandom_range(0, 9))
        0:       size = '0;
        1:       size = $urandom();
        default: size = $urandom_range(1, 256);
      endcase
      start = $urandom();
      if ($urandom_range(0, 7) == 0) start = 32'hFFFF_FF00 | $urandom_range(0, 255);
      put_beat(REQ_LOAD, $urandom_range(0, 1), size, $urandom_range(0, 31), start);
    end else begin
      case ($urandom_range(0, 19))
        0, 1:    size = '0;
        2:       size = $urandom();
        3, 4:    size = $urandom_range(65, 512);
        default: size = $urandom_range(1, 64);
      endcase
      put_beat(REQ_ALLOC, $urandom_range(0, 1), size, $urandom_range(0, 31), $urandom());
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    int burst_left;
    in_valid       <= 1'b0;
    in_req_type    <= REQ_LOAD;
    in_fit_policy  <= POL_BEST;
    in_req_size    <= '0;
    in_slot_index  <= '0;
    in_block_start <= '0;
    rst_n          <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty table, extremes, ties, wraps, exact fits, zero sizes
    put_beat(REQ_ALLOC, POL_BEST,  32'd1,          5'd0,  '0);
    put_beat(REQ_LOAD,  POL_BEST,  32'd100,        5'd0,  32'h0000_1000);
    put_beat(REQ_LOAD,  POL_BEST,  32'h40,         5'd31, 32'hFFFF_FFF0);
    put_beat(REQ_LOAD,  POL_WORST, 32'hFFFF_FFFF,  5'd7,  32'hFFFF_FFFF);
    put_beat(REQ_LOAD,  POL_BEST,  32'd100,        5'd12, 32'h8000_0000);
    put_beat(REQ_LOAD,  POL_BEST,  32'd0,          5'd20, 32'h1234_5678);
    put_beat(REQ_ALLOC, POL_BEST,  32'd0,          5'd0,  '0);
    put_beat(REQ_ALLOC, POL_WORST, 32'd0,          5'd0,  '0);
    put_beat(REQ_ALLOC, POL_BEST,  32'd100,        5'd0,  '0);
    put_beat(REQ_ALLOC, POL_BEST,  32'h20,         5'd0,  '0);
    put_beat(REQ_ALLOC, POL_WORST, 32'h10,         5'd0,  '0);
    put_beat(REQ_ALLOC, POL_BEST,  32'hFFFF_FFFF,  5'd0,  '0);
    put_beat(REQ_ALLOC, POL_WORST, 32'hFFFF_FFEF,  5'd31, 32'hFFFF_FFFF);
    put_beat(REQ_LOAD,  POL_BEST,  32'h5555_5555,  5'd3,  32'hAAAA_AAAA);
    put_beat(REQ_LOAD,  POL_WORST, 32'hAAAA_AAAA,  5'd4,  32'h5555_5555);
    put_beat(REQ_ALLOC, POL_WORST, 32'd1,          5'd0,  '0);
    put_beat(REQ_ALLOC, POL_BEST,  32'h20,         5'd0,  '0);
    put_beat(REQ_ALLOC, POL_BEST,  32'd50,         5'd0,  '0);
    put_beat(REQ_LOAD,  POL_BEST,  32'd0,          5'd12, 32'd0);
    put_beat(REQ_ALLOC, POL_BEST,  32'h8000_0000,  5'd0,  '0);
    drain();

    // random: bursts with gaps, one full drain halfway
    burst_left = 0;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 2) drain();
      if (burst_left == 0) begin
        pause_input($urandom_range(0, 8));
        burst_left = $urandom_range(1, 24);
      end
      send_random();
      burst_left--;
    end

    // wait for the last results, then let the block settle
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("sent %0d loads and %0d allocates (%0d worst fit, %0d best fit)",
             loads_sent, allocs_sent, worst_sent, allocs_sent - worst_sent);
    $display("got %0d grants (%0d exact fits), %0d with no fit, %0d mismatches",
             granted_count, exact_count, nofit_count, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
